// ===== design/ocp_pkg.sv =====
// Package for the order crossover core: field widths, request codes and the
// packed item types used on the core's channels.
// No dependencies; used by order_crossover_permutation_core.
package ocp_pkg;

    localparam int GENE_W      = 11;
    localparam int CUT_START_W = 10;
    localparam int CUT_END_W   = 11;
    localparam int COUNT_W     = 11;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 11'd4;

    typedef struct packed {
        logic                   req_type;
        logic [GENE_W-1:0]      gene_a;
        logic [GENE_W-1:0]      gene_b;
        logic [CUT_START_W-1:0] cut_start;
        logic [CUT_END_W-1:0]   cut_end;
        logic                   last_pair;
    } in_item_t;

    typedef struct packed {
        logic [GENE_W-1:0] child_gene;
        logic              last_gene;
        logic              fault;
    } out_item_t;

endpackage

// ===== design/order_crossover_permutation_core.sv =====
// Order crossover (OX1) core: loads two parent permutations, then drains the child.
// Holds the parent gene memory and the taken-gene map; depends on ocp_pkg.
//
// Usage:
//   item channel (item_valid / item_stall / item): load transactions write one
//   position of both parents; the first load of a job carries the cut points.
//   Drain transactions return one child gene each on the result channel
//   (result_valid / result_stall / result). Load transactions give no result.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes gene_count; write it
//   only while no transaction is in flight.
// Timing:
//   The first load of a job starts a clearing pass over every slot of the taken
//   map (ST_CLEAR), then ST_MARK, with item_stall high throughout.
//   A drain inside the cut segment makes one gene memory read (ST_SEG).
//   A drain outside the segment skips the taken genes of parent B; the crawler
//   loop (parent B read, then taken map read) is pipelined to one gene per cycle.
//   Drains refused for no job, a bad count or bad cuts are answered from ST_IDLE.
// Reset clears all control state, sets gene_count to 1024 and drops any job.
// When the receiver stalls, the result stays in the output register; the core
// keeps accepting loads and holds one more finished drain result internally.
module order_crossover_permutation_core #(
    parameter int MAX_GENES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  ocp_pkg::in_item_t                item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output ocp_pkg::out_item_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ocp_pkg::COUNT_W-1:0]      cfg_data
);

    localparam int GW     = ocp_pkg::GENE_W;
    localparam int ADDR_W = $clog2(MAX_GENES);
    localparam int POS_W  = $clog2(MAX_GENES + 1);
    localparam int SLOT_W = POS_W;
    localparam int CW     = (POS_W > 12) ? POS_W : 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_SEG,
        ST_CRAWL,
        ST_EMIT
    } state_t;

    // map slot of a gene: out-of-range genes share slot zero
    function automatic logic [SLOT_W-1:0] slot_of(input logic [GW-1:0] gene);
        logic [SLOT_W-1:0] s;
        s = '0;
        if (CW'(gene) <= CW'(MAX_GENES))
        begin
            s = SLOT_W'(gene);
        end
        return s;
    endfunction

    // memories
    logic [2*GW-1:0] gene_mem [MAX_GENES];
    logic            taken_mem [MAX_GENES + 1];

    state_t                     state_reg;
    logic [ocp_pkg::COUNT_W-1:0] gene_count_reg;
    logic [POS_W-1:0]           load_pos_reg;
    logic [POS_W-1:0]           out_pos_reg;
    logic [POS_W-1:0]           crawler_reg;
    logic [ocp_pkg::CUT_START_W-1:0] seg_low_reg;
    logic [ocp_pkg::CUT_END_W-1:0]   seg_high_reg;
    logic                       job_loaded_reg;
    logic [SLOT_W-1:0]          clr_idx_reg;
    logic                       pend_mark_reg;
    logic [SLOT_W-1:0]          pend_slot_reg;
    logic [POS_W-1:0]           fetch_reg;
    logic [POS_W-1:0]           s1_pos_reg;
    logic                       s2_valid_reg;
    logic [POS_W-1:0]           s2_pos_reg;
    logic [GW-1:0]              s2_gene_reg;
    logic                       drain_last_reg;
    ocp_pkg::out_item_t         held_reg;
    logic                       result_valid_reg;
    ocp_pkg::out_item_t         result_reg;

    logic [GW-1:0]              gm_a_q;
    logic [GW-1:0]              gm_b_q;
    logic                       tm_q;

    logic                       accept;
    logic                       is_load;
    logic                       is_drain;
    logic                       out_free;
    logic                       count_ok;
    logic                       cuts_ok;
    logic                       out_in_seg;
    logic                       load_in_seg;
    logic                       load_fits;
    logic                       drain_wrap;
    logic [POS_W-1:0]           out_pos_inc;
    logic                       s2_past_end;

    logic                       gm_we;
    logic [ADDR_W-1:0]          gm_waddr;
    logic [ADDR_W-1:0]          gm_a_addr;
    logic [ADDR_W-1:0]          gm_b_addr;
    logic                       tm_we;
    logic [SLOT_W-1:0]          tm_waddr;
    logic                       tm_wdata;
    logic [SLOT_W-1:0]          tm_raddr;

    logic                       r_fire;
    ocp_pkg::out_item_t         r_item;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign is_load      = accept && (item.req_type == ocp_pkg::REQ_LOAD);
    assign is_drain     = accept && (item.req_type == ocp_pkg::REQ_DRAIN);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    assign count_ok = (gene_count_reg >= ocp_pkg::COUNT_MIN)
                   && (CW'(gene_count_reg) <= CW'(MAX_GENES));
    assign cuts_ok  = (CW'(seg_low_reg) + CW'(2) <= CW'(seg_high_reg))
                   && (seg_high_reg <= gene_count_reg);
    assign out_in_seg  = (CW'(out_pos_reg) >= CW'(seg_low_reg))
                      && (CW'(out_pos_reg) < CW'(seg_high_reg));
    assign load_in_seg = (CW'(load_pos_reg) >= CW'(seg_low_reg))
                      && (CW'(load_pos_reg) < CW'(seg_high_reg));
    assign load_fits   = (CW'(load_pos_reg) < CW'(MAX_GENES));
    assign out_pos_inc = out_pos_reg + POS_W'(1);
    assign drain_wrap  = (CW'(out_pos_reg) + CW'(1) >= CW'(gene_count_reg));
    assign s2_past_end = (CW'(s2_pos_reg) >= CW'(gene_count_reg));

    // gene memory ports
    assign gm_we     = is_load && load_fits;
    assign gm_waddr  = load_pos_reg[ADDR_W-1:0];
    assign gm_a_addr = out_pos_reg[ADDR_W-1:0];
    assign gm_b_addr = (state_reg == ST_CRAWL) ? fetch_reg[ADDR_W-1:0]
                                               : crawler_reg[ADDR_W-1:0];
    assign tm_raddr  = slot_of(gm_b_q);

    always_ff @(posedge clk)
    begin
        if (gm_we)
        begin
            gene_mem[gm_waddr] <= {item.gene_a, item.gene_b};
        end
        gm_a_q <= gene_mem[gm_a_addr][2*GW-1:GW];
        gm_b_q <= gene_mem[gm_b_addr][GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            taken_mem[tm_waddr] <= tm_wdata;
        end
        tm_q <= taken_mem[tm_raddr];
    end

    // taken map write port and result selection
    always_comb
    begin
        tm_we    = 1'b0;
        tm_waddr = slot_of(item.gene_a);
        tm_wdata = 1'b1;
        r_fire   = 1'b0;
        r_item   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_load && load_fits && (load_pos_reg != '0) && load_in_seg)
                begin
                    tm_we = 1'b1;
                end
                if (is_drain)
                begin
                    if (!job_loaded_reg)
                    begin
                        r_fire       = 1'b1;
                        r_item.fault = 1'b1;
                    end
                    else if (!count_ok)
                    begin
                        r_fire           = 1'b1;
                        r_item.fault     = 1'b1;
                        r_item.last_gene = 1'b1;
                    end
                    else if (!cuts_ok)
                    begin
                        r_fire           = 1'b1;
                        r_item.fault     = 1'b1;
                        r_item.last_gene = drain_wrap;
                    end
                end
            end
            ST_CLEAR:
            begin
                tm_we    = 1'b1;
                tm_waddr = clr_idx_reg;
                tm_wdata = 1'b0;
            end
            ST_MARK:
            begin
                tm_we    = pend_mark_reg;
                tm_waddr = pend_slot_reg;
            end
            ST_SEG:
            begin
                r_fire            = 1'b1;
                r_item.child_gene = gm_a_q;
                r_item.last_gene  = drain_last_reg;
            end
            ST_CRAWL:
            begin
                if (s2_valid_reg && (s2_past_end || !tm_q))
                begin
                    r_fire           = 1'b1;
                    r_item.last_gene = drain_last_reg;
                    if (s2_past_end)
                    begin
                        r_item.fault = 1'b1;
                    end
                    else
                    begin
                        r_item.child_gene = s2_gene_reg;
                        tm_we             = 1'b1;
                        tm_waddr          = slot_of(s2_gene_reg);
                    end
                end
            end
            ST_EMIT:
            begin
                r_fire = 1'b0;
            end
            default:
            begin
                r_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gene_count_reg   <= ocp_pkg::COUNT_RESET;
            load_pos_reg     <= '0;
            out_pos_reg      <= '0;
            crawler_reg      <= '0;
            seg_low_reg      <= '0;
            seg_high_reg     <= '0;
            job_loaded_reg   <= 1'b0;
            clr_idx_reg      <= '0;
            pend_mark_reg    <= 1'b0;
            pend_slot_reg    <= '0;
            fetch_reg        <= '0;
            s1_pos_reg       <= '0;
            s2_valid_reg     <= 1'b0;
            s2_pos_reg       <= '0;
            s2_gene_reg      <= '0;
            drain_last_reg   <= 1'b0;
            held_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gene_count_reg <= cfg_data;
            end
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (is_load)
                    begin
                        if (load_fits)
                        begin
                            load_pos_reg <= load_pos_reg + POS_W'(1);
                        end
                        if (load_pos_reg == '0)
                        begin
                            // job start: latch cuts, then sweep the taken map
                            seg_low_reg    <= item.cut_start;
                            seg_high_reg   <= item.cut_end;
                            job_loaded_reg <= 1'b0;
                            pend_mark_reg  <= (item.cut_start == '0) && (item.cut_end != '0);
                            pend_slot_reg  <= slot_of(item.gene_a);
                            clr_idx_reg    <= '0;
                            state_reg      <= ST_CLEAR;
                        end
                        if (item.last_pair)
                        begin
                            job_loaded_reg <= 1'b1;
                            load_pos_reg   <= '0;
                            out_pos_reg    <= '0;
                            crawler_reg    <= '0;
                        end
                    end
                    else if (is_drain && job_loaded_reg)
                    begin
                        if (!count_ok || drain_wrap)
                        begin
                            job_loaded_reg <= 1'b0;
                            out_pos_reg    <= '0;
                        end
                        else
                        begin
                            out_pos_reg <= out_pos_inc;
                        end
                        drain_last_reg <= drain_wrap;
                        if (count_ok && cuts_ok)
                        begin
                            if (out_in_seg)
                            begin
                                state_reg <= ST_SEG;
                            end
                            else
                            begin
                                s1_pos_reg   <= crawler_reg;
                                fetch_reg    <= crawler_reg + POS_W'(1);
                                s2_valid_reg <= 1'b0;
                                state_reg    <= ST_CRAWL;
                            end
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                    if (clr_idx_reg == SLOT_W'(MAX_GENES))
                    begin
                        state_reg <= ST_MARK;
                    end
                end
                ST_MARK:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SEG:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_CRAWL:
                begin
                    // parent B read -> taken map read -> check, one gene a cycle
                    s2_valid_reg <= 1'b1;
                    s2_pos_reg   <= s1_pos_reg;
                    s2_gene_reg  <= gm_b_q;
                    s1_pos_reg   <= fetch_reg;
                    fetch_reg    <= fetch_reg + POS_W'(1);
                    if (r_fire)
                    begin
                        crawler_reg <= s2_past_end ? s2_pos_reg : s2_pos_reg + POS_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        result_reg       <= held_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (r_fire)
            begin
                if (out_free)
                begin
                    result_valid_reg <= 1'b1;
                    result_reg       <= r_item;
                    state_reg        <= ST_IDLE;
                end
                else
                begin
                    held_reg  <= r_item;
                    state_reg <= ST_EMIT;
                end
            end
        end
    end

endmodule

// ===== tb/sv/order_crossover_permutation_core_test.sv =====
// Self-checking testbench for order_crossover_permutation_core: a queue-fed driver,
// a monitor that predicts each child gene and checks it, and random idling on both sides.
// Depends on ocp_pkg and the core RTL.
module order_crossover_permutation_core_test;

    localparam int     MAX_GENES     = 1024;
    localparam int     CLK_PERIOD    = 20;
    localparam int     RESET_CYCLES  = 12;
    localparam int     RANDOM_ITEMS  = 120;
    localparam int     SETTLE_CYCLES = MAX_GENES + 32;
    localparam int     DRAIN_LIMIT   = 100000;
    localparam int     HOLD_AFTER    = 52;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     PRINT_LIMIT   = 40;
    localparam longint LIMIT_CYCLES  = 10000000;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        item_valid   = 1'b0;
    logic                        item_stall;
    ocp_pkg::in_item_t           item         = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    ocp_pkg::out_item_t          result;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [ocp_pkg::COUNT_W-1:0] cfg_data     = '0;

    // stimulus and expectations
    ocp_pkg::in_item_t  pending_items[$];
    ocp_pkg::out_item_t child_queue[$];
    ocp_pkg::out_item_t want;
    int                 perm_a[MAX_GENES];
    int                 perm_b[MAX_GENES];

    // predictor state
    logic [ocp_pkg::GENE_W-1:0] copy_a[MAX_GENES];
    logic [ocp_pkg::GENE_W-1:0] copy_b[MAX_GENES];
    bit                         gene_used[0:MAX_GENES];
    int                         gene_total  = int'(ocp_pkg::COUNT_RESET);
    int                         fill_pos    = 0;
    int                         emit_pos    = 0;
    int                         scan_pos    = 0;
    int                         cut_lo      = 0;
    int                         cut_hi      = 0;
    bit                         child_armed = 1'b0;

    // bookkeeping
    bit item_taken     = 1'b0;
    bit calm           = 1'b0;
    bit hold_done      = 1'b0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int items_in       = 0;
    int stim_count     = 0;
    int count_writes   = 0;
    int wait_cycles    = 0;
    int new_count      = 0;
    int pick           = 0;

    order_crossover_permutation_core #(
        .MAX_GENES(MAX_GENES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("order_crossover_permutation_core_test: errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // genes above the map size share slot zero
    function automatic int slot_of(input logic [ocp_pkg::GENE_W-1:0] g);
        return (g <= MAX_GENES) ? int'(g) : 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at result %0d, %s: got %0d, want %0d",
                     results_seen, what, got, exp_val);
    endtask

    task automatic crossover_step(input ocp_pkg::in_item_t req);
        ocp_pkg::out_item_t res;
        int                 p;
        if (req.req_type == ocp_pkg::REQ_LOAD)
        begin
            if (fill_pos == 0)
            begin
                for (int g = 0; g <= MAX_GENES; g++)
                    gene_used[g] = 1'b0;
                cut_lo      = int'(req.cut_start);
                cut_hi      = int'(req.cut_end);
                child_armed = 1'b0;
            end
            // positions past the store are dropped
            if (fill_pos < MAX_GENES)
            begin
                copy_a[fill_pos] = req.gene_a;
                copy_b[fill_pos] = req.gene_b;
                if (fill_pos >= cut_lo && fill_pos < cut_hi)
                    gene_used[slot_of(req.gene_a)] = 1'b1;
                fill_pos++;
            end
            if (req.last_pair)
            begin
                child_armed = 1'b1;
                fill_pos    = 0;
                emit_pos    = 0;
                scan_pos    = 0;
            end
        end
        else
        begin
            res = '0;
            if (!child_armed)
                res.fault = 1'b1;
            else if (gene_total < int'(ocp_pkg::COUNT_MIN) || gene_total > MAX_GENES)
            begin
                res.fault     = 1'b1;
                res.last_gene = 1'b1;
                child_armed   = 1'b0;
                emit_pos      = 0;
            end
            else
            begin
                p = emit_pos;
                if (!(cut_lo + 2 <= cut_hi && cut_hi <= gene_total))
                    res.fault = 1'b1;
                else if (p >= cut_lo && p < cut_hi)
                    res.child_gene = copy_a[p];
                else
                begin
                    while (scan_pos < gene_total && gene_used[slot_of(copy_b[scan_pos])])
                        scan_pos++;
                    if (scan_pos >= gene_total)
                        res.fault = 1'b1;
                    else
                    begin
                        res.child_gene = copy_b[scan_pos];
                        gene_used[slot_of(copy_b[scan_pos])] = 1'b1;
                        scan_pos++;
                    end
                end
                if (p + 1 >= gene_total)
                begin
                    res.last_gene = 1'b1;
                    child_armed   = 1'b0;
                    emit_pos      = 0;
                end
                else
                    emit_pos = p + 1;
            end
            child_queue.push_back(res);
        end
    endtask

    // monitor: check the result first, then predict the transaction accepted at this edge
    always @(posedge clk)
    begin
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (child_queue.size() == 0)
                    report_mismatch("result with nothing expected", 32'(result), 32'(0));
                else
                begin
                    want = child_queue.pop_front();
                    if (result.child_gene !== want.child_gene)
                        report_mismatch("child_gene", 32'(result.child_gene),
                                        32'(want.child_gene));
                    if (result.last_gene !== want.last_gene)
                        report_mismatch("last_gene", 32'(result.last_gene),
                                        32'(want.last_gene));
                    if (result.fault !== want.fault)
                        report_mismatch("fault", 32'(result.fault), 32'(want.fault));
                end
            end
            if (item_valid && !item_stall)
            begin
                items_in++;
                crossover_step(item);
            end
            item_taken <= item_valid && !item_stall;
        end
    end

    // driver: a new transaction only once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                gap_left = calm ? 0 : idle_len();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off while the sender is still busy
    always @(negedge clk)
    begin
        if (!hold_done && results_seen >= HOLD_AFTER && pending_items.size() > 20)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = calm ? 0 : idle_len();
            result_stall <= 1'b0;
        end
    end

    task automatic add_load(input int ga, input int gb, input int cs, input int ce,
                            input bit lp);
        ocp_pkg::in_item_t t;
        t.req_type  = ocp_pkg::REQ_LOAD;
        t.gene_a    = ga[ocp_pkg::GENE_W-1:0];
        t.gene_b    = gb[ocp_pkg::GENE_W-1:0];
        t.cut_start = cs[ocp_pkg::CUT_START_W-1:0];
        t.cut_end   = ce[ocp_pkg::CUT_END_W-1:0];
        t.last_pair = lp;
        pending_items.push_back(t);
        stim_count++;
    endtask

    // the other fields of a drain are don't-care, so they carry noise
    task automatic add_drain();
        ocp_pkg::in_item_t t;
        logic [63:0]       noise;
        noise      = {$urandom, $urandom};
        t          = noise[$bits(ocp_pkg::in_item_t)-1:0];
        t.req_type = ocp_pkg::REQ_DRAIN;
        pending_items.push_back(t);
        stim_count++;
    endtask

    task automatic fill_parents(input int n);
        int j;
        int t;
        for (int i = 0; i < n; i++)
        begin
            perm_a[i] = i + 1;
            perm_b[i] = i + 1;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm_a[i];
            perm_a[i] = perm_a[j];
            perm_a[j] = t;
            j = $urandom_range(0, i);
            t = perm_b[i];
            perm_b[i] = perm_b[j];
            perm_b[j] = t;
        end
    endtask

    task automatic gen_job(input int nload, input int cs, input int ce, input int ndrain,
                           input bit noisy);
        int span;
        span = (nload > MAX_GENES) ? MAX_GENES : nload;
        fill_parents(span);
        // duplicates, gene zero and genes past the map
        if (noisy)
            repeat ($urandom_range(1, 3))
            begin
                perm_a[$urandom_range(0, span - 1)] = $urandom_range(0, 2047);
                perm_b[$urandom_range(0, span - 1)] = $urandom_range(0, 2047);
            end
        for (int i = 0; i < nload; i++)
            add_load(perm_a[i % span], perm_b[i % span],
                     (i == 0) ? cs : $urandom_range(0, 1023),
                     (i == 0) ? ce : $urandom_range(0, 2047), i == nload - 1);
        repeat (ndrain) add_drain();
    endtask

    task automatic gen_random_job(input int count);
        int n;
        int cs;
        int ce;
        int r;
        n  = (count >= int'(ocp_pkg::COUNT_MIN) && count <= MAX_GENES) ?
             count : $urandom_range(4, 12);
        cs = $urandom_range(0, n - 2);
        ce = $urandom_range(cs + 2, n);
        r  = $urandom_range(0, 99);
        if (count == MAX_GENES)
        begin
            // full size: short load, partial drain over earlier store contents
            cs = $urandom_range(0, 6);
            ce = cs + $urandom_range(2, 6);
            gen_job($urandom_range(4, 12), cs, ce, $urandom_range(4, 16),
                    $urandom_range(0, 3) == 0);
        end
        else if (r < 70)
            gen_job(n, cs, ce, ($urandom_range(0, 6) == 0) ? $urandom_range(1, n - 1) : n, 0);
        else if (r < 78)
            gen_job(n, $urandom_range(0, 1023), $urandom_range(0, 2047),
                    $urandom_range(1, n + 2), 0);
        else if (r < 86)
            gen_job(n, cs, ce, n, 1);
        else if (r < 93)
            gen_job($urandom_range(1, n + 4), cs, ce, $urandom_range(0, n + 3), 0);
        else
            repeat ($urandom_range(1, 4)) add_drain();
    endtask

    // sender pauses until every expected result is back and the core has gone quiet
    task automatic flush_phase();
        while (pending_items.size() != 0 || item_valid || child_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[ocp_pkg::COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        gene_total = value & ((1 << ocp_pkg::COUNT_W) - 1);
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain with no job loaded
        add_drain();
        flush_phase();

        write_count(int'(ocp_pkg::COUNT_MIN));
        // segment at the left edge, rest filled from parent B
        add_load(2, 3, 0, 2, 0);
        add_load(4, 1, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(1, 4, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(3, 2, $urandom_range(0, 1023), $urandom_range(0, 2047), 1);
        repeat (4) add_drain();
        // parent B repeats genes, so the crawler runs dry on the last position
        add_load(1, 1, 1, 3, 0);
        add_load(2, 2, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(3, 1, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(4, 2, $urandom_range(0, 1023), $urandom_range(0, 2047), 1);
        repeat (4) add_drain();
        // one-position segment is rejected; job stays open
        add_load(4, 1, 2, 3, 0);
        add_load(3, 2, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(2, 3, $urandom_range(0, 1023), $urandom_range(0, 2047), 0);
        add_load(1, 4, $urandom_range(0, 1023), $urandom_range(0, 2047), 1);
        add_drain();
        flush_phase();

        // out-of-range count closes the open job
        write_count(0);
        add_drain();
        flush_phase();

        // full-size job with the cuts at their top and two overflow loads
        write_count(MAX_GENES);
        gen_job(MAX_GENES + 2, 1021, 1024, 40, 1'b0);
        flush_phase();

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                new_count = $urandom_range(4, 12);
            else if (pick < 85)
                new_count = $urandom_range(13, 48);
            else if (pick < 92)
                new_count = MAX_GENES;
            else if (pick < 96)
                new_count = $urandom_range(0, 3);
            else
                new_count = $urandom_range(MAX_GENES + 1, 2047);
            write_count(new_count);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 6)) gen_random_job(new_count);
            flush_phase();
        end

        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        wait_cycles = 0;
        while (child_queue.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (child_queue.size() != 0)
            report_mismatch("child genes never delivered", 32'(0), child_queue.size());

        $display("run covered %0d transactions in, %0d child genes checked, %0d count writes",
                 items_in, results_seen, count_writes);
        $display("incl. bad cuts and counts, crawler exhaustion, overflow and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("order_crossover_permutation_core_test: clean");
        else
            $display("order_crossover_permutation_core_test: errors");
        $finish;
    end

endmodule
